// ===== design/b32e_pkg.sv =====
// ----------------------------------------------------------------------------
// b32e_pkg: shared types and functions of the base32 encoder
// Holds the queue entry format and the 5-bit group to ASCII mapping.
// ----------------------------------------------------------------------------
package b32e_pkg;

  // Width of one base32 group and of one output character
  localparam int unsigned GroupWidth = 5;
  localparam int unsigned CharWidth  = 7;

  // ASCII anchors of the two alphabet ranges
  localparam logic [6:0] CharLowerA = 7'h61;  // 'a'
  localparam logic [6:0] CharDigit2 = 7'h32;  // '2'
  localparam logic [4:0] DigitBase  = 5'd26;  // first group value mapped to a digit

  typedef logic [GroupWidth-1:0] group_t;
  typedef logic [CharWidth-1:0]  char_t;

  // One classified input byte: up to three groups, left to right
  typedef struct packed {
    group_t     g0;
    group_t     g1;
    group_t     g2;
    logic [1:0] count;  // number of groups in use, 1..3
    logic       last;   // final character of the message is in this entry
  } entry_t;

  // Front to queue
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Group value to lowercase alphabet character
  function automatic char_t sym_of(input group_t g);
    char_t c;
    if (g < DigitBase) begin
      c = CharLowerA + char_t'(g);
    end else begin
      c = CharDigit2 + char_t'(g - DigitBase);
    end
    return c;
  endfunction

endpackage

// ===== design/b32e_byte_if.sv =====
// ----------------------------------------------------------------------------
// b32e_byte_if: byte input channel
// valid/ready handshake carrying one message byte and its end mark.
// ----------------------------------------------------------------------------
interface b32e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== design/b32e_char_if.sv =====
// ----------------------------------------------------------------------------
// b32e_char_if: character output channel
// valid/ready handshake carrying one ASCII character and its last mark.
// ----------------------------------------------------------------------------
interface b32e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

// ===== design/base32_lowercase_encoder.sv =====
// ----------------------------------------------------------------------------
// base32_lowercase_encoder: streaming base32 encoder, lowercase, no padding
// Front groups bytes into 5-bit values, a queue decouples, back emits ASCII.
// ----------------------------------------------------------------------------
// Channel      Role   Payload                          Transaction
// byte_stream  sink   data_byte[7:0], end_of_message   one message byte
// char_stream  source code_char[6:0], last_char        one ASCII character
//
// One character leaves per cycle while char_stream is ready; a byte makes one
// or two characters, two or three on the final byte.
// The front takes a byte in the cycle it arrives while the queue has room.
// Synchronous reset clears leftover bits, queue and output valid; no sweep.
// A stalled char_stream fills the queue, then byte_stream.ready drops.
// ----------------------------------------------------------------------------
module base32_lowercase_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  b32e_byte_if.sink    byte_stream,
  b32e_char_if.source  char_stream
);

  b32e_pkg::push_t push;
  b32e_pkg::head_t head;
  logic            q_full;
  logic            pop;

  b32e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_stream.valid),
    .data_byte      (byte_stream.data_byte),
    .end_of_message (byte_stream.end_of_message),
    .byte_ready     (byte_stream.ready),
    .q_full         (q_full),
    .push           (push)
  );

  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  b32e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .char_valid (char_stream.valid),
    .char_ready (char_stream.ready),
    .code_char  (char_stream.code_char),
    .last_char  (char_stream.last_char)
  );

endmodule

// ===== design/b32e_front.sv =====
// ----------------------------------------------------------------------------
// b32e_front: byte intake and grouping
// Joins leftover bits with each byte, splits into 5-bit groups and queues them.
// ----------------------------------------------------------------------------
module b32e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  output logic              byte_ready,
  input  logic              q_full,
  output b32e_pkg::push_t   push
);

  logic [3:0]  pending_bits, pending_bits_next;
  logic [2:0]  pending_count, pending_count_next;

  logic [3:0]  keep_mask;
  logic [11:0] val;
  logic [11:0] aligned;
  logic [3:0]  total;
  logic        two_full;
  logic [2:0]  rem;
  logic [3:0]  rem_mask;
  logic        take;

  assign byte_ready = !q_full;
  assign take       = byte_valid && !q_full;

  // Leftover bits above the byte, then left-justify the valid bits
  always_comb begin
    keep_mask = 4'((5'd1 << pending_count) - 5'd1);
    val       = {pending_bits & keep_mask, data_byte};
    aligned   = 12'(val << (3'd4 - pending_count));
    total     = 4'(pending_count) + 4'd8;
    two_full  = (total >= 4'd10);
    rem       = two_full ? 3'(total - 4'd10) : 3'(total - 4'd5);
    rem_mask  = 4'((5'd1 << rem) - 5'd1);
  end

  // Entry: groups read straight off the left-justified word, zero fill below
  always_comb begin
    push.push        = take;
    push.entry.g0    = aligned[11:7];
    push.entry.g1    = aligned[6:2];
    push.entry.g2    = {aligned[1:0], 3'b000};
    push.entry.last  = end_of_message;
    if (two_full) begin
      push.entry.count = (end_of_message && rem != 3'd0) ? 2'd3 : 2'd2;
    end else begin
      push.entry.count = end_of_message ? 2'd2 : 2'd1;
    end
  end

  // Leftover state, cleared at end of message
  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (take) begin
      if (end_of_message) begin
        pending_bits_next  = 4'd0;
        pending_count_next = 3'd0;
      end else begin
        pending_bits_next  = val[3:0] & rem_mask;
        pending_count_next = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 4'd0;
      pending_count <= 3'd0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== design/b32e_queue.sv =====
// ----------------------------------------------------------------------------
// b32e_queue: entry queue between front and back
// Small FIFO of grouped bytes; first-word view for the back end.
// ----------------------------------------------------------------------------
module b32e_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  b32e_pkg::push_t  push,
  output logic             full,
  output b32e_pkg::head_t  head,
  input  logic             pop
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  b32e_pkg::entry_t slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  fill;
  logic             do_push, do_pop;

  assign full       = (fill == FullCnt);
  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// ===== design/b32e_back.sv =====
// ----------------------------------------------------------------------------
// b32e_back: character emitter
// Walks the groups of the head entry into an output register, one character
// per cycle while the output register is not stalled.
// ----------------------------------------------------------------------------
module b32e_back (
  input  logic               clk,
  input  logic               rst,
  input  b32e_pkg::head_t    head,
  output logic               pop,
  output logic               char_valid,
  input  logic               char_ready,
  output b32e_pkg::char_t    code_char,
  output logic               last_char
);

  logic [1:0]        idx;
  logic              load;
  logic              final_group;
  b32e_pkg::group_t  sel;

  assign load        = head.valid && (!char_valid || char_ready);
  assign final_group = (idx == head.entry.count - 2'd1);
  assign pop         = load && final_group;

  // Group select
  always_comb begin
    case (idx)
      2'd0:    sel = head.entry.g0;
      2'd1:    sel = head.entry.g1;
      default: sel = head.entry.g2;
    endcase
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      code_char <= b32e_pkg::sym_of(sel);
      last_char <= head.entry.last && final_group;
    end
  end

  // Output valid and group index
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (!char_valid || char_ready) begin
        char_valid <= head.valid;
      end
      if (load) begin
        idx <= final_group ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

// ===== design/b32e_checker.sv =====
// ----------------------------------------------------------------------------
// b32e_checker: port-level checks of the base32 encoder
// Output handshake, alphabet range and reset behaviour.
// ----------------------------------------------------------------------------
module b32e_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input logic [6:0] code_char,
  input logic       last_char
);

  // Stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(code_char) && $stable(last_char))
    else $error("character changed while stalled");

  // Only lowercase letters and digits 2..7 are ever shown
  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((code_char >= 7'h61) && (code_char <= 7'h7a)) ||
                   ((code_char >= 7'h32) && (code_char <= 7'h37)))
    else $error("character outside base32 alphabet");

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("output valid after reset");

endmodule

bind base32_lowercase_encoder b32e_checker u_b32e_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_stream.valid),
  .char_ready (char_stream.ready),
  .code_char  (char_stream.code_char),
  .last_char  (char_stream.last_char)
);

// ===== verif/base32_lowercase_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base32_lowercase_encoder_tb: self-checking bench for the base32 encoder
// Drives messages of bytes into byte_stream and keeps a scoreboard that
// encodes the same bytes into lowercase, unpadded base32. Every character on
// char_stream is checked against it, including the last-character flag.
// Sender gaps and receiver stalls are varied, and one long receiver hold-off
// fills the block.
// ----------------------------------------------------------------------------
module base32_lowercase_encoder_tb;

  localparam int unsigned StallLimit   = 2000;  // cycles with no transaction
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 60;

  // One encoded character as seen on char_stream
  typedef struct {
    b32e_pkg::char_t code;
    logic            last;
  } enc_char_t;

  // Scoreboard: running encoder state and the characters still owed
  class char_scoreboard;
    logic [3:0]  held_bits;
    logic [2:0]  held_count;
    enc_char_t   awaited[$];
    int unsigned mismatches;

    function new();
      held_bits  = '0;
      held_count = '0;
      mismatches = 0;
    endfunction

    // 0..25 -> 'a'..'z', 26..31 -> '2'..'7' ('2' - 26 = 0x18)
    function b32e_pkg::char_t group_char(b32e_pkg::group_t g);
      return (g < 5'd26) ? b32e_pkg::char_t'(8'h61 + g) : b32e_pkg::char_t'(8'h18 + g);
    endfunction

    function void add_char(b32e_pkg::group_t g, logic is_last);
      enc_char_t c;
      c.code = group_char(g);
      c.last = is_last;
      awaited.push_back(c);
    endfunction

    // An accepted byte: emit full groups, then the zero-filled tail on the end
    function void note_byte(logic [7:0] value, logic eom);
      logic [11:0] acc;
      int unsigned nbits;
      // bits above the count are zero anyway; mask to be safe
      acc   = {held_bits & ((4'd1 << held_count) - 4'd1), value};
      nbits = held_count + 8;
      while (nbits >= 5) begin
        nbits -= 5;
        add_char(b32e_pkg::group_t'(acc >> nbits), eom && (nbits == 0));
      end
      acc = acc & ((12'd1 << nbits) - 12'd1);
      if (eom) begin
        if (nbits > 0) begin
          add_char(b32e_pkg::group_t'(acc << (5 - nbits)), 1'b1);
        end
        held_bits  = '0;
        held_count = '0;
      end else begin
        held_bits  = acc[3:0];
        held_count = nbits[2:0];
      end
    endfunction

    // An accepted character: compare with the oldest one owed
    function void check_char(b32e_pkg::char_t code, logic last);
      enc_char_t want;
      if (awaited.size() == 0) begin
        $error("unexpected character: code_char %h last_char %b", code, last);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (code !== want.code) begin
        $error("code_char: expected %h, actual %h", want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_char: expected %b, actual %b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  b32e_byte_if byte_ch();
  b32e_char_if char_ch();

  char_scoreboard scoreboard;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_seq = 0;      // bumped by the stimulus to ask for a hold-off
  int unsigned    quiet_cycles = 0;

  base32_lowercase_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_ch),
    .char_stream (char_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL base32_lowercase_encoder");
      $finish;
    end
  end

  // Receiver: random stalls, plus a counted hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        char_ch.ready = 1'b0;
        hold_left--;
      end else begin
        char_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (!rst && char_ch.valid && char_ch.ready) begin
        scoreboard.check_char(char_ch.code_char, char_ch.last_char);
      end
    end
  end

  // Biased byte value: extremes now and then
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] value, input logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid          = 1'b1;
    byte_ch.data_byte      = value;
    byte_ch.end_of_message = eom;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    scoreboard.note_byte(value, eom);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(random_byte(), i == len - 1);
    end
  endtask

  // Random messages: mostly short, some multiples of five, a few long ones
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned items);
    int unsigned sent;
    int unsigned len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0:       len = 5 * $urandom_range(1, 3);
        1:       len = $urandom_range(12, 30);
        default: len = $urandom_range(1, 8);
      endcase
      send_message(len);
      sent += len;
    end
  endtask

  initial begin
    scoreboard             = new();
    rst                    = 1'b1;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = '0;
    byte_ch.end_of_message = 1'b0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: all-ones messages of one to five bytes cover every tail length
    for (int unsigned len = 1; len <= 5; len++) begin
      for (int unsigned i = 0; i < len; i++) begin
        send_byte(8'hff, i == len - 1);
      end
    end
    send_byte(8'h00, 1'b1);
    // five bytes, no fill character: the last full group is flagged
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h7e, 1'b1);

    // Random traffic; a long receiver hold-off while bytes keep coming
    run_phase(0, 0, 20);
    hold_seq++;
    run_phase(0, 0, 20);
    run_phase(64, 0, 50);
    run_phase(0, 64, 50);
    run_phase(38, 38, 50);
    byte_ch.valid = 1'b0;

    // Drain, then let the block settle
    while (scoreboard.awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.awaited.size() == 0) begin
      $display("PASS base32_lowercase_encoder");
    end else begin
      $display("FAIL base32_lowercase_encoder");
    end
    $finish;
  end

endmodule
